/* rtl/crmpm_pkg.sv */
`timescale 1ns / 1ps

package crmpm_pkg;

   // Matrix geometry: six rows, f terms in rows 0..2 and g terms in rows 3..5.
   localparam int MATRIX_ORDER   = 6;
   localparam int LAST_IDX       = MATRIX_ORDER - 1;
   localparam int HALF_ORDER     = MATRIX_ORDER / 2;
   localparam int ROW_G          = HALF_ORDER;
   localparam int FIRST_COMPUTED = 3;

   // Matrix store addressing: {slot, row, column}.
   localparam int POS_BITS  = 3;
   localparam int SLOT_BITS = 2;
   localparam int ADDR_BITS = SLOT_BITS + 2 * POS_BITS;

   localparam logic MAT_ACC  = 1'b0;
   localparam logic MAT_BASE = 1'b1;

   // Default widths of the datapath.
   localparam int DEF_VALUE_WIDTH = 16;
   localparam int DEF_INDEX_WIDTH = 31;

   // Configuration register indexes.
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int NUM_COEFS       = 6;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_F_PREV1 = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_F_PREV2 = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_F_CROSS = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_G_PREV1 = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_G_PREV2 = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_G_CROSS = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MODULUS = 3'd6;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_WAIT,
      ST_DECIDE,
      ST_MUL,
      ST_FINAL,
      ST_FIN_WAIT,
      ST_DONE
   } state_type;

   typedef enum logic {
      OP_ACC,
      OP_SQUARE
   } op_type;

   typedef enum logic [1:0] {
      DEST_MEM,
      DEST_F,
      DEST_G
   } dest_type;

   typedef enum logic [1:0] {
      SRC_MEM,
      SRC_ONE,
      SRC_ZERO
   } a_src_type;

   // Travels with each product through the multiplier pipeline.
   typedef struct packed {
      logic                 first;
      logic                 last;
      dest_type             dest;
      logic [ADDR_BITS-1:0] addr;
   } tag_type;

endpackage

/* rtl/coupled_recurrence_matrix_power_mod.sv */
`timescale 1ns / 1ps

// The work per word is P matrix products, P being the bit length of n-2 minus
// one, plus the set bits of n-2; an index below 3 needs no matrix product.
// One word is handled at a time, through the one pipelined modular
// multiply-accumulate unit, fed at one product a cycle from the matrix store.
// Reset is synchronous: control clears, coefficients go to 0 and the modulus to 1.
module coupled_recurrence_matrix_power_mod #(
   parameter int VALUE_WIDTH = crmpm_pkg::DEF_VALUE_WIDTH,
   parameter int INDEX_WIDTH = crmpm_pkg::DEF_INDEX_WIDTH
) (
   input  logic clock,
   input  logic reset,
   // Request word: term_index, f_init0, f_init1, f_init2, g_init0, g_init1, g_init2.
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [((INDEX_WIDTH + crmpm_pkg::MATRIX_ORDER * VALUE_WIDTH + 7) / 8) * 8 - 1:0]
                req_tdata,
   // Response word: f_value, g_value.
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [((2 * VALUE_WIDTH + 7) / 8) * 8 - 1:0] rsp_tdata,
   // Register write channel.
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [crmpm_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [VALUE_WIDTH-1:0] csr_data
);
   import crmpm_pkg::*;

   localparam int VW    = VALUE_WIDTH;
   localparam int IW    = INDEX_WIDTH;
   localparam int RW    = VW + 2;
   localparam int RSP_W = ((2 * VW + 7) / 8) * 8;
   localparam int DEPTH = 1 << ADDR_BITS;

   // Control state.
   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic [IW-1:0] expo_ff, expo_in;
   logic small_ff, small_in;
   logic [1:0] col_ff, col_in;
   logic acc_sel_ff, acc_sel_in;
   logic base_sel_ff, base_sel_in;
   logic [POS_BITS-1:0] cnt_r_ff, cnt_r_in;
   logic [POS_BITS-1:0] cnt_c_ff, cnt_c_in;
   logic [POS_BITS-1:0] cnt_k_ff, cnt_k_in;

   // Configuration.
   logic [VW-1:0] coef_ff [NUM_COEFS];
   logic [VW-1:0] mod_ff;
   logic [VW-1:0] m_eff;
   logic [VW-1:0] one_val;
   logic [RW-1:0] m_ext;
   logic [RW-1:0] m_dbl;

   // Request capture.
   logic [VW-1:0] init_ff [MATRIX_ORDER];
   logic [VW-1:0] req_vec [MATRIX_ORDER];
   logic [IW-1:0] n_w;
   logic req_take;

   // Issue side.
   logic iss_v;
   tag_type iss_tag;
   a_src_type iss_asrc;
   logic iss_bmem;
   logic [VW-1:0] iss_braw;
   logic [VW-1:0] base_raw;
   logic [ADDR_BITS-1:0] addr_a;
   logic [ADDR_BITS-1:0] addr_b;
   logic [POS_BITS-1:0] col_sel;
   logic last_r, last_c, last_k;

   // Matrix store and its read stage.
   logic [VW-1:0] mem [0:DEPTH-1];
   logic [VW-1:0] rd_a_ff, rd_b_ff;
   logic iss_v_ff;
   tag_type iss_tag_ff;
   a_src_type iss_asrc_ff;
   logic iss_bmem_ff;
   logic [VW-1:0] iss_braw_ff;
   logic [VW-1:0] op_x, op_y;

   // Bit-serial modular multiplier pipeline, one stage per multiplier bit.
   logic [VW-1:0] p_x_ff [0:VW];
   logic [VW-1:0] p_y_ff [0:VW];
   logic [RW-1:0] p_r_ff [0:VW];
   tag_type p_tag_ff [0:VW];
   logic [VW:0] p_v_ff;
   logic pipe_busy;

   // Accumulation and results.
   logic [VW-1:0] dot_ff;
   logic [RW-1:0] dot_sum;
   logic [VW-1:0] dot_next;
   logic wr_en;
   logic [ADDR_BITS-1:0] wr_addr;
   logic [VW-1:0] f_res_ff, g_res_ff;
   logic rsp_tvalid_ff;
   logic [VW-1:0] rsp_f_ff, rsp_g_ff;

   // A modulus of zero behaves as one.
   assign m_eff   = (mod_ff == '0) ? VW'(1) : mod_ff;
   assign one_val = (m_eff == VW'(1)) ? '0 : VW'(1);
   assign m_ext   = RW'(m_eff);
   assign m_dbl   = m_ext << 1;

   assign csr_ready = 1'b1;
   assign req_take  = req_tvalid && req_tready;
   assign n_w       = req_tdata[IW-1:0];

   // The state vector runs f2, f1, f0, g2, g1, g0; the word carries f0 first.
   always_comb begin
      int fi;
      for (int c = 0; c < MATRIX_ORDER; c++) begin
         fi = (c < HALF_ORDER) ? (HALF_ORDER - 1 - c) : (MATRIX_ORDER + HALF_ORDER - 1 - c);
         req_vec[c] = req_tdata[IW + fi * VW +: VW];
      end
   end

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_COEFS; i++) begin
            coef_ff[i] <= '0;
         end
         mod_ff <= VW'(1);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_F_PREV1, REG_F_PREV2, REG_F_CROSS,
            REG_G_PREV1, REG_G_PREV2, REG_G_CROSS: begin
               coef_ff[csr_index] <= csr_data;
            end
            REG_MODULUS: begin
               mod_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   assign last_r = (cnt_r_ff == POS_BITS'(LAST_IDX));
   assign last_c = (cnt_c_ff == POS_BITS'(LAST_IDX));
   assign last_k = (cnt_k_ff == POS_BITS'(LAST_IDX));

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (cnt_k_ff[0] && last_r && last_c) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (!pipe_busy) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (expo_ff == '0) begin
               state_in = ST_FINAL;
            end else if (expo_ff[0]) begin
               state_in = ST_MUL;
            end else if ((expo_ff >> 1) == '0) begin
               state_in = ST_FINAL;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (last_r && last_c && last_k) begin
               state_in = ST_WAIT;
            end
         end
         ST_FINAL: begin
            if ((cnt_r_ff == POS_BITS'(ROW_G)) && last_c) begin
               state_in = ST_FIN_WAIT;
            end
         end
         ST_FIN_WAIT: begin
            if (!pipe_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_tvalid_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer counters, exponent and slot pointers.
   always_comb begin
      cnt_r_in    = cnt_r_ff;
      cnt_c_in    = cnt_c_ff;
      cnt_k_in    = cnt_k_ff;
      acc_sel_in  = acc_sel_ff;
      base_sel_in = base_sel_ff;
      expo_in     = expo_ff;
      op_in       = op_ff;
      small_in    = small_ff;
      col_in      = col_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cnt_r_in    = '0;
               cnt_c_in    = '0;
               cnt_k_in    = '0;
               acc_sel_in  = 1'b0;
               base_sel_in = 1'b0;
               small_in    = (n_w < IW'(FIRST_COMPUTED));
               col_in      = 2'(HALF_ORDER - 1) - n_w[1:0];
               expo_in     = small_in ? '0 : (n_w - IW'(FIRST_COMPUTED - 1));
            end
         end
         ST_LOAD: begin
            // Column fastest, then row, then which matrix.
            if (last_c) begin
               cnt_c_in = '0;
               if (last_r) begin
                  cnt_r_in = '0;
                  cnt_k_in = cnt_k_ff + POS_BITS'(1);
               end else begin
                  cnt_r_in = cnt_r_ff + POS_BITS'(1);
               end
            end else begin
               cnt_c_in = cnt_c_ff + POS_BITS'(1);
            end
         end
         ST_DECIDE: begin
            cnt_r_in = '0;
            cnt_c_in = '0;
            cnt_k_in = '0;
            if (expo_ff != '0) begin
               if (expo_ff[0]) begin
                  op_in   = OP_ACC;
                  expo_in = expo_ff & ~IW'(1);
               end else begin
                  op_in   = OP_SQUARE;
                  expo_in = expo_ff >> 1;
               end
            end
         end
         ST_MUL: begin
            // Inner index fastest, then column, then row.
            if (last_k) begin
               cnt_k_in = '0;
               if (last_c) begin
                  cnt_c_in = '0;
                  if (last_r) begin
                     cnt_r_in = '0;
                     if (op_ff == OP_ACC) begin
                        acc_sel_in = ~acc_sel_ff;
                     end else begin
                        base_sel_in = ~base_sel_ff;
                     end
                  end else begin
                     cnt_r_in = cnt_r_ff + POS_BITS'(1);
                  end
               end else begin
                  cnt_c_in = cnt_c_ff + POS_BITS'(1);
               end
            end else begin
               cnt_k_in = cnt_k_ff + POS_BITS'(1);
            end
         end
         ST_FINAL: begin
            // Row of f first, then the row of g.
            if (last_c) begin
               cnt_c_in = '0;
               cnt_r_in = POS_BITS'(ROW_G);
            end else begin
               cnt_c_in = cnt_c_ff + POS_BITS'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         op_ff       <= OP_ACC;
         expo_ff     <= '0;
         small_ff    <= 1'b0;
         col_ff      <= '0;
         acc_sel_ff  <= 1'b0;
         base_sel_ff <= 1'b0;
         cnt_r_ff    <= '0;
         cnt_c_ff    <= '0;
         cnt_k_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         op_ff       <= op_in;
         expo_ff     <= expo_in;
         small_ff    <= small_in;
         col_ff      <= col_in;
         acc_sel_ff  <= acc_sel_in;
         base_sel_ff <= base_sel_in;
         cnt_r_ff    <= cnt_r_in;
         cnt_c_ff    <= cnt_c_in;
         cnt_k_ff    <= cnt_k_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         for (int c = 0; c < MATRIX_ORDER; c++) begin
            init_ff[c] <= req_vec[c];
         end
      end
   end

   // Companion matrix entries before reduction.
   always_comb begin
      base_raw = '0;
      case (cnt_r_ff)
         3'd0: begin
            if (cnt_c_ff == 3'd0) begin
               base_raw = coef_ff[REG_F_PREV1];
            end else if (cnt_c_ff == 3'd1) begin
               base_raw = coef_ff[REG_F_PREV2];
            end else if (cnt_c_ff == 3'd5) begin
               base_raw = coef_ff[REG_F_CROSS];
            end
         end
         3'd1: begin
            if (cnt_c_ff == 3'd0) begin
               base_raw = VW'(1);
            end
         end
         3'd2: begin
            if (cnt_c_ff == 3'd1) begin
               base_raw = VW'(1);
            end
         end
         3'd3: begin
            if (cnt_c_ff == 3'd2) begin
               base_raw = coef_ff[REG_G_CROSS];
            end else if (cnt_c_ff == 3'd3) begin
               base_raw = coef_ff[REG_G_PREV1];
            end else if (cnt_c_ff == 3'd4) begin
               base_raw = coef_ff[REG_G_PREV2];
            end
         end
         3'd4: begin
            if (cnt_c_ff == 3'd3) begin
               base_raw = VW'(1);
            end
         end
         3'd5: begin
            if (cnt_c_ff == 3'd4) begin
               base_raw = VW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // Column picked for an index below 3.
   assign col_sel = (cnt_r_ff == '0) ? POS_BITS'(col_ff)
                                     : POS_BITS'(col_ff) + POS_BITS'(ROW_G);

   // Outputs of the sequencer: handshake and issue of one product a cycle.
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      iss_v      = 1'b0;
      iss_tag    = '0;
      iss_asrc   = SRC_MEM;
      iss_bmem   = 1'b0;
      iss_braw   = '0;
      addr_a     = '0;
      addr_b     = '0;
      case (state_ff)
         ST_LOAD: begin
            // Every entry goes through the multiplier as one times itself mod m.
            iss_v         = 1'b1;
            iss_tag.first = 1'b1;
            iss_tag.last  = 1'b1;
            iss_tag.dest  = DEST_MEM;
            iss_asrc      = SRC_ONE;
            if (cnt_k_ff[0]) begin
               iss_tag.addr = {MAT_BASE, base_sel_ff, cnt_r_ff, cnt_c_ff};
               iss_braw     = base_raw;
            end else begin
               iss_tag.addr = {MAT_ACC, acc_sel_ff, cnt_r_ff, cnt_c_ff};
               iss_braw     = (cnt_r_ff == cnt_c_ff) ? VW'(1) : '0;
            end
         end
         ST_MUL: begin
            iss_v         = 1'b1;
            iss_tag.first = (cnt_k_ff == '0);
            iss_tag.last  = last_k;
            iss_tag.dest  = DEST_MEM;
            iss_bmem      = 1'b1;
            addr_b        = {MAT_BASE, base_sel_ff, cnt_k_ff, cnt_c_ff};
            if (op_ff == OP_ACC) begin
               addr_a       = {MAT_ACC, acc_sel_ff, cnt_r_ff, cnt_k_ff};
               iss_tag.addr = {MAT_ACC, ~acc_sel_ff, cnt_r_ff, cnt_c_ff};
            end else begin
               addr_a       = {MAT_BASE, base_sel_ff, cnt_r_ff, cnt_k_ff};
               iss_tag.addr = {MAT_BASE, ~base_sel_ff, cnt_r_ff, cnt_c_ff};
            end
         end
         ST_FINAL: begin
            iss_v         = 1'b1;
            iss_tag.first = (cnt_c_ff == '0);
            iss_tag.last  = last_c;
            iss_tag.dest  = (cnt_r_ff == '0) ? DEST_F : DEST_G;
            addr_a        = {MAT_ACC, acc_sel_ff, cnt_r_ff, cnt_c_ff};
            iss_braw      = init_ff[cnt_c_ff];
            if (small_ff) begin
               iss_asrc = (cnt_c_ff == col_sel) ? SRC_ONE : SRC_ZERO;
            end
         end
         default: begin
         end
      endcase
   end

   // Matrix store: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= dot_next;
      end
      rd_a_ff     <= mem[addr_a];
      rd_b_ff     <= mem[addr_b];
      iss_tag_ff  <= iss_tag;
      iss_asrc_ff <= iss_asrc;
      iss_bmem_ff <= iss_bmem;
      iss_braw_ff <= iss_braw;
   end

   // Operand selection after the read stage.
   always_comb begin
      case (iss_asrc_ff)
         SRC_MEM:  op_x = rd_a_ff;
         SRC_ONE:  op_x = one_val;
         SRC_ZERO: op_x = '0;
         default:  op_x = '0;
      endcase
      op_y = iss_bmem_ff ? rd_b_ff : iss_braw_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iss_v_ff <= 1'b0;
         p_v_ff   <= '0;
      end else begin
         iss_v_ff <= iss_v;
         p_v_ff   <= {p_v_ff[VW-1:0], iss_v_ff};
      end
   end

   always_ff @(posedge clock) begin
      p_x_ff[0]   <= op_x;
      p_y_ff[0]   <= op_y;
      p_r_ff[0]   <= '0;
      p_tag_ff[0] <= iss_tag_ff;
   end

   // Each stage takes one multiplier bit, most significant first:
   // r = 2r + bit * x, brought back below m. x is always below m.
   for (genvar j = 0; j < VW; j++) begin : g_stage
      logic [RW-1:0] sum_w;
      logic [RW-1:0] red_w;

      always_comb begin
         sum_w = (p_r_ff[j] << 1) + (p_y_ff[j][VW-1] ? RW'(p_x_ff[j]) : '0);
         if (sum_w >= m_dbl) begin
            red_w = sum_w - m_dbl;
         end else if (sum_w >= m_ext) begin
            red_w = sum_w - m_ext;
         end else begin
            red_w = sum_w;
         end
      end

      always_ff @(posedge clock) begin
         p_x_ff[j+1]   <= p_x_ff[j];
         p_y_ff[j+1]   <= p_y_ff[j] << 1;
         p_r_ff[j+1]   <= red_w;
         p_tag_ff[j+1] <= p_tag_ff[j];
      end
   end

   assign pipe_busy = iss_v_ff || (p_v_ff != '0);

   // Modular accumulation of each dot product.
   always_comb begin
      dot_sum = (p_tag_ff[VW].first ? '0 : RW'(dot_ff)) + p_r_ff[VW];
      if (dot_sum >= m_ext) begin
         dot_next = VW'(dot_sum - m_ext);
      end else begin
         dot_next = VW'(dot_sum);
      end
   end

   assign wr_en   = p_v_ff[VW] && p_tag_ff[VW].last && (p_tag_ff[VW].dest == DEST_MEM);
   assign wr_addr = p_tag_ff[VW].addr;

   always_ff @(posedge clock) begin
      if (p_v_ff[VW]) begin
         dot_ff <= dot_next;
         if (p_tag_ff[VW].last && (p_tag_ff[VW].dest == DEST_F)) begin
            f_res_ff <= dot_next;
         end
         if (p_tag_ff[VW].last && (p_tag_ff[VW].dest == DEST_G)) begin
            g_res_ff <= dot_next;
         end
      end
   end

   // Output register: holds a word until taken while the next one is accepted.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if ((state_ff == ST_DONE) && !rsp_tvalid_ff) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_DONE) && !rsp_tvalid_ff) begin
         rsp_f_ff <= f_res_ff;
         rsp_g_ff <= g_res_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = RSP_W'({rsp_g_ff, rsp_f_ff});

   // A product never writes into a slot that it is still reading.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (wr_en && (state_ff == ST_MUL)) |->
         ((wr_addr[ADDR_BITS-1 -: SLOT_BITS] != addr_a[ADDR_BITS-1 -: SLOT_BITS]) &&
          (wr_addr[ADDR_BITS-1 -: SLOT_BITS] != addr_b[ADDR_BITS-1 -: SLOT_BITS])))
      else $error("matrix write lands in a source slot");

   // Every product leaving the multiplier is fully reduced.
   a_reduced: assert property (@(posedge clock) disable iff (reset)
      p_v_ff[VW] |-> (p_r_ff[VW] < m_ext))
      else $error("multiplier output not below the modulus");

   // A new request is only taken with the pipeline empty.
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !pipe_busy)
      else $error("request accepted while products are in flight");

   // An accumulate product runs only once the low exponent bit is consumed.
   a_expo_bit: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_MUL) && (op_ff == OP_ACC)) |-> !expo_ff[0])
      else $error("exponent bit not cleared for accumulate product");

   // A response only appears out of the done state.
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside the done state");

endmodule
